>>> hdl/trp_pkg.sv
// shared constants, codes and control types of the redundant text packetizer
package trp_pkg;

  localparam int MAX_CHUNK   = 16;
  localparam int OFFSET_MASK = 16383;
  localparam int SLOTS       = 4;
  localparam int STORE_DEPTH = SLOTS * MAX_CHUNK;

  localparam int BYTE_W   = 8;
  localparam int TIME_W   = 32;
  localparam int PT_W     = 7;
  localparam int OFF_W    = 14;
  localparam int HLEN_W   = 10;
  localparam int SLOT_W   = 2;
  localparam int FILL_W   = $clog2(MAX_CHUNK + 1);
  localparam int LEN_W    = FILL_W;
  localparam int STORE_AW = $clog2(STORE_DEPTH);
  // position counter covers the nine header bytes and one chunk
  localparam int IDX_W    = ($clog2(MAX_CHUNK) > 4) ? $clog2(MAX_CHUNK) : 4;
  localparam int HDR_LAST = 8;

  typedef logic op_t;
  localparam op_t OP_TEXT = 1'b0;
  localparam op_t OP_TICK = 1'b1;

  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_REDUNDANCY_ON = 2'd0;
  localparam reg_index_t REG_RED_PT        = 2'd1;
  localparam reg_index_t REG_PRI_PT        = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_CHECK,
    ST_FETCH,
    ST_LOAD,
    ST_ERR
  } state_t;

  typedef enum logic [1:0] {
    SEG_HDR,
    SEG_R2,
    SEG_R1,
    SEG_P
  } seg_t;

  typedef struct packed {
    logic capture;
    logic store;
    logic rotate;
    logic zero_times;
    logic seq_start;
    logic fetch;
    logic load;
    logic load_err;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic chunk_open;
    logic chunk_end;
    logic overflow_now;
    logic all_empty;
    logic send_none;
    logic out_free;
    logic seq_done;
  } status_t;

endpackage

>>> hdl/trp_if.sv
// valid/ready channels: text input, packet output, register write
interface trp_in_if;
  import trp_pkg::*;
  logic              valid;
  logic              ready;
  op_t               opcode;
  logic [BYTE_W-1:0] text_byte;
  logic              chunk_end;
  logic [TIME_W-1:0] chunk_time;
  modport source(output valid, opcode, text_byte, chunk_end, chunk_time, input ready);
  modport sink(input valid, opcode, text_byte, chunk_end, chunk_time, output ready);
endinterface

interface trp_out_if;
  import trp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic              out_status;
  modport source(output valid, out_byte, out_last, out_status, input ready);
  modport sink(input valid, out_byte, out_last, out_status, output ready);
endinterface

interface trp_cfg_if;
  import trp_pkg::*;
  logic            valid;
  logic            ready;
  reg_index_t      index;
  logic [PT_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> hdl/trp_datapath.sv
// text store, generation registers, packet sequencer and output register
module trp_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  trp_pkg::cmd_t             cmd,
  output trp_pkg::status_t          st,
  input  trp_pkg::op_t              in_opcode,
  input  logic [trp_pkg::BYTE_W-1:0] in_text_byte,
  input  logic                      in_chunk_end,
  input  logic [trp_pkg::TIME_W-1:0] in_chunk_time,
  trp_out_if.source                 out_ch,
  trp_cfg_if.sink                   cfg
);
  import trp_pkg::*;

  // configuration
  logic            redundancy_on;
  logic [PT_W-1:0] red_pt;
  logic [PT_W-1:0] pri_pt;

  // captured item
  op_t               item_op;
  logic [BYTE_W-1:0] item_byte;
  logic              item_end;
  logic [TIME_W-1:0] item_time;

  // chunk collection and generations (index 0 primary, 1 R1, 2 R2)
  logic [FILL_W-1:0] fill;
  logic              overflow;
  logic [SLOT_W-1:0] slot_base;
  logic [LEN_W-1:0]  gen_len  [3];
  logic [TIME_W-1:0] gen_time [3];
  logic [LEN_W-1:0]  new_len;

  logic [BYTE_W-1:0] text_store [STORE_DEPTH];
  logic [BYTE_W-1:0] rd_data;
  logic [STORE_AW-1:0] wr_addr;
  logic [STORE_AW-1:0] rd_addr;
  logic [SLOT_W-1:0] wr_slot;
  logic [SLOT_W-1:0] rd_slot;
  logic              wr_en;
  logic              fill_full;

  // packet sequencer
  seg_t             seg;
  logic [IDX_W-1:0] idx;
  seg_t             nseg;
  logic [IDX_W-1:0] nidx;
  logic             ndone;
  logic [LEN_W-1:0] seg_len;

  // header byte
  logic              hdr_r1;
  logic [LEN_W-1:0]  hdr_len;
  logic [TIME_W-1:0] hdr_time;
  logic [TIME_W-1:0] diff;
  logic [OFF_W-1:0]  off;
  logic [OFF_W+HLEN_W-1:0] word;
  logic [BYTE_W-1:0] hdr_byte;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      redundancy_on <= 1'b0;
      red_pt        <= '0;
      pri_pt        <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_REDUNDANCY_ON: redundancy_on <= cfg.data[0];
        REG_RED_PT:        red_pt        <= cfg.data;
        REG_PRI_PT:        pri_pt        <= cfg.data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_op   <= in_opcode;
      item_byte <= in_text_byte;
      item_end  <= in_chunk_end;
      item_time <= in_chunk_time;
    end
  end

  assign fill_full = (fill == FILL_W'(MAX_CHUNK));
  assign wr_en     = cmd.store && !fill_full;
  assign wr_slot   = slot_base + SLOT_W'(3);
  assign wr_addr   = STORE_AW'(int'(wr_slot) * MAX_CHUNK + int'(fill));

  always_comb begin
    case (seg)
      SEG_R2:  rd_slot = slot_base + SLOT_W'(2);
      SEG_R1:  rd_slot = slot_base + SLOT_W'(1);
      default: rd_slot = slot_base;
    endcase
  end
  assign rd_addr = STORE_AW'(int'(rd_slot) * MAX_CHUNK + int'(idx));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      text_store[wr_addr] <= item_byte;
    end
    if (cmd.fetch) begin
      rd_data <= text_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      overflow <= 1'b0;
    end else if (cmd.store) begin
      if (item_end) begin
        fill     <= '0;
        overflow <= 1'b0;
      end else if (!fill_full) begin
        fill <= fill + FILL_W'(1);
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  assign new_len = (item_op == OP_TICK) ? '0 : LEN_W'(fill + FILL_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_base <= '0;
      for (int g = 0; g < 3; g++) begin
        gen_len[g]  <= '0;
        gen_time[g] <= '0;
      end
    end else if (cmd.rotate) begin
      slot_base   <= slot_base - SLOT_W'(1);
      gen_len[2]  <= gen_len[1];
      gen_len[1]  <= gen_len[0];
      gen_len[0]  <= new_len;
      gen_time[2] <= gen_time[1];
      gen_time[1] <= gen_time[0];
      gen_time[0] <= item_time;
    end else if (cmd.zero_times) begin
      for (int g = 0; g < 3; g++) begin
        gen_time[g] <= '0;
      end
    end
  end

  // header: bytes 0..3 describe R2, 4..7 describe R1, byte 8 is the primary type
  assign hdr_r1   = (idx >= IDX_W'(4));
  assign hdr_len  = hdr_r1 ? gen_len[1] : gen_len[2];
  assign hdr_time = hdr_r1 ? gen_time[1] : gen_time[2];
  assign diff     = (gen_time[0] - hdr_time) & TIME_W'(OFFSET_MASK);
  assign off      = diff[OFF_W-1:0];
  assign word     = {off, HLEN_W'(hdr_len)};

  always_comb begin
    case (idx)
      IDX_W'(0), IDX_W'(4): hdr_byte = {1'b1, red_pt};
      IDX_W'(1), IDX_W'(5): hdr_byte = word[23:16];
      IDX_W'(2), IDX_W'(6): hdr_byte = word[15:8];
      IDX_W'(3), IDX_W'(7): hdr_byte = word[7:0];
      default:              hdr_byte = {1'b0, pri_pt};
    endcase
  end

  always_comb begin
    case (seg)
      SEG_R2:  seg_len = gen_len[2];
      SEG_R1:  seg_len = gen_len[1];
      default: seg_len = gen_len[0];
    endcase
  end

  // next position, skipping empty generations
  always_comb begin
    nseg  = seg;
    nidx  = idx + IDX_W'(1);
    ndone = 1'b0;
    case (seg)
      SEG_HDR: begin
        if (idx == IDX_W'(HDR_LAST)) begin
          nidx = '0;
          if (gen_len[2] != '0) nseg = SEG_R2;
          else if (gen_len[1] != '0) nseg = SEG_R1;
          else if (gen_len[0] != '0) nseg = SEG_P;
          else ndone = 1'b1;
        end
      end
      SEG_R2: begin
        if (int'(idx) + 1 >= int'(seg_len)) begin
          nidx = '0;
          if (gen_len[1] != '0) nseg = SEG_R1;
          else if (gen_len[0] != '0) nseg = SEG_P;
          else ndone = 1'b1;
        end
      end
      SEG_R1: begin
        if (int'(idx) + 1 >= int'(seg_len)) begin
          nidx = '0;
          if (gen_len[0] != '0) nseg = SEG_P;
          else ndone = 1'b1;
        end
      end
      default: begin
        if (int'(idx) + 1 >= int'(seg_len)) begin
          ndone = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.seq_start) begin
      seg <= redundancy_on ? SEG_HDR : SEG_P;
      idx <= '0;
    end else if (cmd.load) begin
      seg <= nseg;
      idx <= nidx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.load || cmd.load_err) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_ch.out_byte   <= (seg == SEG_HDR) ? hdr_byte : rd_data;
      out_ch.out_last   <= ndone;
      out_ch.out_status <= 1'b0;
    end else if (cmd.load_err) begin
      out_ch.out_byte   <= '0;
      out_ch.out_last   <= 1'b1;
      out_ch.out_status <= 1'b1;
    end
  end

  assign st.is_tick      = (item_op == OP_TICK);
  assign st.chunk_open   = (fill != '0) || overflow;
  assign st.chunk_end    = item_end;
  assign st.overflow_now = overflow || fill_full;
  assign st.all_empty    = (gen_len[0] == '0) && (gen_len[1] == '0) && (gen_len[2] == '0);
  assign st.send_none    = !redundancy_on && (gen_len[0] == '0);
  assign st.out_free     = !out_ch.valid || out_ch.ready;
  assign st.seq_done     = ndone;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(MAX_CHUNK))
    else $error("chunk fill beyond limit");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow |-> fill_full)
    else $error("overflow flag without a full chunk");

  a_idle_reset: assert property (@(posedge clk) disable iff (rst)
    cmd.zero_times |=> (gen_time[0] == '0) && (gen_time[1] == '0) && (gen_time[2] == '0)
                       && (gen_len[0] == '0) && (gen_len[1] == '0) && (gen_len[2] == '0))
    else $error("idle generations not cleared");
`endif

endmodule

>>> hdl/trp_controller.sv
// state machine that sequences item handling and packet output
module trp_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  trp_pkg::status_t st,
  output trp_pkg::cmd_t    cmd
);
  import trp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (st.is_tick) begin
          state_next = st.chunk_open ? ST_IDLE : ST_CHECK;
        end else if (!st.chunk_end) begin
          state_next = ST_IDLE;
        end else if (st.overflow_now) begin
          state_next = ST_ERR;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = (st.all_empty || st.send_none) ? ST_IDLE : ST_FETCH;
      end
      ST_FETCH: state_next = ST_LOAD;
      ST_LOAD: begin
        if (st.out_free) state_next = st.seq_done ? ST_IDLE : ST_FETCH;
      end
      ST_ERR: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_APPLY: begin
        cmd.store  = !st.is_tick;
        cmd.rotate = st.is_tick ? !st.chunk_open : (st.chunk_end && !st.overflow_now);
      end
      ST_CHECK: begin
        cmd.zero_times = st.all_empty;
        cmd.seq_start  = !st.all_empty && !st.send_none;
      end
      ST_FETCH: cmd.fetch    = 1'b1;
      ST_LOAD:  cmd.load     = st.out_free;
      ST_ERR:   cmd.load_err = st.out_free;
      default:  ;
    endcase
  end

endmodule

>>> hdl/text_redundancy_packetizer_unit.sv
// top level of the redundant real-time text packetizer
// an item is captured, then applied; a clean chunk end or tick outside a chunk adds CHECK
// each packet byte passes FETCH (text store read), then LOAD (output register load)
// closing item passes APPLY, CHECK and FETCH; LOAD sets the first byte valid; up to 57 bytes
// the output register lets the next item in while the last byte waits to be taken
// synchronous reset clears generations, chunk state, configuration registers and the output valid
module text_redundancy_packetizer_unit (
  input  logic      clk,
  input  logic      rst,
  trp_in_if.sink    in_ch,
  trp_out_if.source out_ch,
  trp_cfg_if.sink   cfg
);
  import trp_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    in_ready;

  assign in_ch.ready = in_ready;

  trp_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  trp_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .in_opcode     (in_ch.opcode),
    .in_text_byte  (in_ch.text_byte),
    .in_chunk_end  (in_ch.chunk_end),
    .in_chunk_time (in_ch.chunk_time),
    .out_ch        (out_ch),
    .cfg           (cfg)
  );

endmodule
